/* sv/wavp_pkg.sv */
// Shared constants, payload types and helpers for the WAV header stream parser.
package wavp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_RIFX = 32'h52494658;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [7:0]  ASCII_LO = 8'd32;
  localparam logic [7:0]  ASCII_HI = 8'd126;
  localparam logic [31:0] FMT_MIN  = 32'd16;
  localparam logic [31:0] FMT_EXT  = 32'd18;

  localparam logic [3:0] ST_PARSING  = 4'd0;
  localparam logic [3:0] ST_AUDIO    = 4'd1;
  localparam logic [3:0] ST_DONE     = 4'd2;
  localparam logic [3:0] ST_BAD_TAG  = 4'd3;
  localparam logic [3:0] ST_SIZE_BAD = 4'd4;
  localparam logic [3:0] ST_NOT_WAVE = 4'd5;
  localparam logic [3:0] ST_NOT_ASCII = 4'd6;
  localparam logic [3:0] ST_OVERRUN  = 4'd7;
  localparam logic [3:0] ST_NOT_FMT  = 4'd8;
  localparam logic [3:0] ST_FMT_BAD  = 4'd9;
  localparam logic [3:0] ST_EARLY    = 4'd10;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       file_start;
  } wavp_in_t;

  typedef struct packed {
    logic [7:0]  audio_byte;
    logic        audio_valid;
    logic        audio_last;
    logic [3:0]  status;
    logic        big_endian;
    logic [15:0] audio_format;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
  } wavp_out_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

/* sv/wavp_in_if.sv */
// Valid/ready channel carrying one input byte beat of the parser.
interface wavp_in_if import wavp_pkg::*; ();
  logic     valid;
  logic     ready;
  wavp_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/wavp_out_if.sv */
// Valid/ready channel carrying one result beat of the parser.
interface wavp_out_if import wavp_pkg::*; ();
  logic      valid;
  logic      ready;
  wavp_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/wav_header_stream_parser.sv */
// WAV header stream parser: checks RIFF/RIFX header and chunks, passes data payload bytes.
//
// Usage:
//   in_i carries one file byte per beat; file_start marks offset 0 of a new file and
//   clears all parse state. cfg_we_i/cfg_wdata_i load the total file size, written
//   while no beat is in flight.
//   out_o returns exactly one result beat per input beat: the byte when it lies in the
//   data payload (audio_valid, audio_last on its final byte), the latched status code,
//   the byte order and the fmt fields decoded so far, and the data chunk size.
//   The result of a beat is registered and presented in the cycle after it is taken.
//   Throughput is one beat per cycle while results are taken; each byte passes through
//   a single compare, shift and count stage between the input handshake and the result
//   register. in_i.ready stays high while the result register is empty or being taken,
//   so a stalled receiver holds at most one result and then stalls the sender.
//   Reset clears the file size register, all parse state and the result valid flag.
//   After an error or the end of the data payload, bytes are consumed and answered
//   with the held status until the next file_start.
module wav_header_stream_parser
  import wavp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  wavp_in_if.sink            in_i,
  wavp_out_if.source         out_o
);

  localparam logic [2:0] PH_RIFF   = 3'd0;
  localparam logic [2:0] PH_FMTHDR = 3'd1;
  localparam logic [2:0] PH_FMTPAY = 3'd2;
  localparam logic [2:0] PH_HDR    = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_STOP   = 3'd6;

  logic [31:0]      tfs_q;
  logic [2:0]       ph_q, ph_d;
  logic [31:0]      off_q, off_d;
  logic             order_q, order_d;
  logic [31:0]      ws_q, ws_d;
  logic             ascii_q, ascii_d;
  logic [31:0]      tag_q, tag_d;
  logic [31:0]      psz_q, psz_d;
  logic [31:0]      left_q, left_d;
  logic [1:0][63:0] fmt_q, fmt_d;
  logic [31:0]      dsz_q, dsz_d;
  logic [15:0]      ext_q, ext_d;
  logic [4:0]       fi_q, fi_d;
  logic [3:0]       st_q, st_d;

  logic             out_valid_q;
  wavp_out_t        out_q, res;
  logic             accept;
  logic             beat_valid, beat_last;
  logic [15:0][7:0] fb;

  assign in_i.ready    = !out_valid_q || out_o.ready;
  assign accept        = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  ph;
    logic [31:0] off;
    logic [2:0]  n;
    logic [31:0] tag_sh;
    logic [31:0] sz;
    logic [15:0] ext;
    logic        hdr_ok;
    logic        pay_ok;

    b      = in_i.payload.byte_value;
    ph     = ph_q;
    off    = off_q;
    hdr_ok = 1'b0;
    pay_ok = 1'b0;
    sz     = '0;
    ext    = '0;

    ph_d    = ph_q;
    off_d   = off_q;
    order_d = order_q;
    ws_d    = ws_q;
    ascii_d = ascii_q;
    tag_d   = tag_q;
    psz_d   = psz_q;
    left_d  = left_q;
    fmt_d   = fmt_q;
    dsz_d   = dsz_q;
    ext_d   = ext_q;
    fi_d    = fi_q;
    st_d    = st_q;

    if (in_i.payload.file_start) begin
      ph      = PH_RIFF;
      off     = '0;
      ph_d    = PH_RIFF;
      off_d   = '0;
      order_d = 1'b0;
      ws_d    = '0;
      ascii_d = 1'b1;
      tag_d   = '0;
      psz_d   = '0;
      left_d  = '0;
      fmt_d   = '0;
      dsz_d   = '0;
      ext_d   = '0;
      fi_d    = '0;
      st_d    = ST_PARSING;
    end

    beat_valid = 1'b0;
    beat_last  = 1'b0;
    tag_sh     = {tag_d[23:0], b};
    n          = left_d[2:0];

    if (ph != PH_STOP) begin
      // chunk header byte collection, shared by both header phases
      if (ph == PH_FMTHDR || ph == PH_HDR) begin
        if (n < 3'd4) begin
          tag_d = tag_sh;
          if (b < ASCII_LO || b > ASCII_HI) begin
            ascii_d = 1'b0;
          end
        end else begin
          ws_d = ws_d | (32'(b) << {n[1:0], 3'b000});
        end
        left_d = 32'(n) + 32'd1;
        if (n == 3'd7) begin
          if (!ascii_d) begin
            ph_d = PH_STOP;
            st_d = ST_NOT_ASCII;
          end else begin
            psz_d = order_d ? swap32(ws_d) : ws_d;
            if ({2'b00, psz_d} + {2'b00, off} + 34'd1 > {2'b00, tfs_q}) begin
              ph_d = PH_STOP;
              st_d = ST_OVERRUN;
            end else begin
              hdr_ok = 1'b1;
            end
          end
        end
      end

      unique case (ph)
        PH_RIFF: begin
          if (off < 32'd4 || (off >= 32'd8 && off < 32'd12)) begin
            tag_d = tag_sh;
          end else if (off < 32'd8) begin
            ws_d = ws_d | (32'(b) << {off[1:0], 3'b000});
          end
          if (off == 32'd3) begin
            if (tag_d == TAG_RIFF) begin
              order_d = 1'b0;
            end else if (tag_d == TAG_RIFX) begin
              order_d = 1'b1;
            end else begin
              ph_d = PH_STOP;
              st_d = ST_BAD_TAG;
            end
            tag_d = '0;
          end else if (off == 32'd7) begin
            sz = order_d ? swap32(ws_d) : ws_d;
            if (sz != tfs_q && {1'b0, sz} + 33'd8 != {1'b0, tfs_q}) begin
              ph_d = PH_STOP;
              st_d = ST_SIZE_BAD;
            end
            ws_d = '0;
          end else if (off >= 32'd11) begin
            if (tag_d != TAG_WAVE) begin
              ph_d = PH_STOP;
              st_d = ST_NOT_WAVE;
            end else begin
              ph_d    = PH_FMTHDR;
              left_d  = '0;
              tag_d   = '0;
              ws_d    = '0;
              ascii_d = 1'b1;
            end
          end
        end
        PH_FMTHDR: begin
          if (hdr_ok) begin
            if (tag_d != TAG_FMT) begin
              ph_d = PH_STOP;
              st_d = ST_NOT_FMT;
            end else if (psz_d < FMT_MIN) begin
              ph_d = PH_STOP;
              st_d = ST_FMT_BAD;
            end else begin
              ph_d   = PH_FMTPAY;
              left_d = psz_d;
              fi_d   = '0;
            end
          end
        end
        PH_FMTPAY: begin
          if (fi_d < 5'd16) begin
            fmt_d[fi_d[3]][{fi_d[2:0], 3'b000} +: 8] =
              fmt_d[fi_d[3]][{fi_d[2:0], 3'b000} +: 8] | b;
          end else if (fi_d < 5'd18) begin
            ext_d[{fi_d[0], 3'b000} +: 8] = ext_d[{fi_d[0], 3'b000} +: 8] | b;
          end
          if (fi_d != 5'd31) begin
            fi_d = fi_d + 5'd1;
          end
          left_d = left_d - 32'd1;
          if (left_d == '0) begin
            ext    = order_d ? {ext_d[7:0], ext_d[15:8]} : ext_d;
            pay_ok = (psz_d == FMT_MIN) ||
                     (psz_d >= FMT_EXT && {16'h0000, ext} == psz_d - FMT_EXT);
            if (pay_ok) begin
              ph_d    = PH_HDR;
              left_d  = '0;
              tag_d   = '0;
              ws_d    = '0;
              ascii_d = 1'b1;
            end else begin
              ph_d = PH_STOP;
              st_d = ST_FMT_BAD;
            end
          end
        end
        PH_HDR: begin
          if (hdr_ok) begin
            if (tag_d == TAG_DATA) begin
              dsz_d = psz_d;
              if (psz_d == '0) begin
                ph_d = PH_STOP;
                st_d = ST_DONE;
              end else begin
                ph_d   = PH_DATA;
                left_d = psz_d;
                st_d   = ST_AUDIO;
              end
            end else if (psz_d == '0) begin
              ph_d    = PH_HDR;
              left_d  = '0;
              tag_d   = '0;
              ws_d    = '0;
              ascii_d = 1'b1;
            end else begin
              ph_d   = PH_SKIP;
              left_d = psz_d;
            end
          end
        end
        PH_SKIP: begin
          left_d = left_d - 32'd1;
          if (left_d == '0) begin
            ph_d    = PH_HDR;
            tag_d   = '0;
            ws_d    = '0;
            ascii_d = 1'b1;
          end
        end
        PH_DATA: begin
          beat_valid = 1'b1;
          left_d     = left_d - 32'd1;
          if (left_d == '0) begin
            beat_last = 1'b1;
            ph_d      = PH_STOP;
            st_d      = ST_DONE;
          end
        end
        default: begin
          ph_d = PH_STOP;
          st_d = ST_EARLY;
        end
      endcase

      if (off != 32'hFFFF_FFFF) begin
        off_d = off + 32'd1;
      end
      if (ph_d != PH_STOP && off_d >= tfs_q) begin
        ph_d = PH_STOP;
        st_d = ST_EARLY;
      end
    end
  end

  assign fb = {fmt_d[1], fmt_d[0]};

  always_comb begin
    res.audio_byte      = beat_valid ? in_i.payload.byte_value : 8'h00;
    res.audio_valid     = beat_valid;
    res.audio_last      = beat_last;
    res.status          = st_d;
    res.big_endian      = order_d;
    res.audio_format    = order_d ? {fb[0], fb[1]} : {fb[1], fb[0]};
    res.num_channels    = order_d ? {fb[2], fb[3]} : {fb[3], fb[2]};
    res.sample_rate     = order_d ? {fb[4], fb[5], fb[6], fb[7]}
                                  : {fb[7], fb[6], fb[5], fb[4]};
    res.byte_rate       = order_d ? {fb[8], fb[9], fb[10], fb[11]}
                                  : {fb[11], fb[10], fb[9], fb[8]};
    res.block_align     = order_d ? {fb[12], fb[13]} : {fb[13], fb[12]};
    res.bits_per_sample = order_d ? {fb[14], fb[15]} : {fb[15], fb[14]};
    res.data_size       = dsz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tfs_q <= '0;
    end else if (cfg_we_i) begin
      tfs_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_RIFF;
      off_q   <= '0;
      order_q <= 1'b0;
      ws_q    <= '0;
      ascii_q <= 1'b1;
      tag_q   <= '0;
      psz_q   <= '0;
      left_q  <= '0;
      fmt_q   <= '0;
      dsz_q   <= '0;
      ext_q   <= '0;
      fi_q    <= '0;
      st_q    <= ST_PARSING;
    end else if (accept) begin
      ph_q    <= ph_d;
      off_q   <= off_d;
      order_q <= order_d;
      ws_q    <= ws_d;
      ascii_q <= ascii_d;
      tag_q   <= tag_d;
      psz_q   <= psz_d;
      left_q  <= left_d;
      fmt_q   <= fmt_d;
      dsz_q   <= dsz_d;
      ext_q   <= ext_d;
      fi_q    <= fi_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

endmodule

/* test/wav_header_stream_parser_test.sv */
// Self-checking testbench for the WAV header stream parser: byte streams, predicted results.
module wav_header_stream_parser_test;
  import wavp_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int ITEM_TARGET = 1100;
  localparam int RANDOM_MIN  = 200;

  typedef enum logic [2:0] {
    PH_TAG, PH_FMT_HDR, PH_FMT_BODY, PH_CHUNK_HDR, PH_SKIP, PH_AUDIO, PH_HALT
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  wavp_in_if  in_ch ();
  wavp_out_if out_ch ();

  wav_header_stream_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser model state
  logic [31:0]  m_file_size = '0;
  parse_phase_e m_phase;
  logic [31:0]  m_offset, m_size_acc, m_tag, m_chunk_size, m_left, m_data_size;
  logic         m_big, m_tag_ascii;
  logic [7:0]   m_fmt [16];
  logic [7:0]   m_ext [2];
  logic [3:0]   m_status;

  wavp_out_t   predicted_beats[$];
  int          mismatch_count;
  int          sent_beats;
  int          hold_req;
  bit          calm;
  logic [7:0]  wav_bytes[$];
  bit          gen_big;

  function automatic void clear_parser();
    m_phase      = PH_TAG;
    m_offset     = '0;
    m_big        = 1'b0;
    m_size_acc   = '0;
    m_tag_ascii  = 1'b1;
    m_tag        = '0;
    m_chunk_size = '0;
    m_left       = '0;
    m_data_size  = '0;
    m_status     = ST_PARSING;
    foreach (m_fmt[i]) m_fmt[i] = '0;
    m_ext[0] = '0;
    m_ext[1] = '0;
  endfunction

  function automatic void stop_with(input logic [3:0] code);
    m_status = code;
    m_phase  = PH_HALT;
  endfunction

  function automatic void open_header(input parse_phase_e ph);
    m_phase     = ph;
    m_left      = '0;
    m_tag       = '0;
    m_size_acc  = '0;
    m_tag_ascii = 1'b1;
  endfunction

  function automatic void gather_size_byte(input logic [7:0] b, input int k);
    if (m_big) m_size_acc = {m_size_acc[23:0], b};
    else m_size_acc[8*k +: 8] = b;
  endfunction

  function automatic bit take_header_byte(input logic [7:0] b, input logic [31:0] off);
    int          n;
    logic [31:0] start;
    logic [32:0] room;
    n = int'(m_left[2:0]);
    if (n < 4) begin
      m_tag = {m_tag[23:0], b};
      if (b < ASCII_LO || b > ASCII_HI) m_tag_ascii = 1'b0;
    end else begin
      gather_size_byte(b, n - 4);
    end
    m_left = 32'(n + 1);
    if (m_left < 8) return 1'b0;
    if (!m_tag_ascii) begin
      stop_with(ST_NOT_ASCII);
      return 1'b0;
    end
    m_chunk_size = m_size_acc;
    start = off - 32'd7;
    room  = (m_file_size > start) ? {1'b0, m_file_size - start} : 33'd0;
    if ({1'b0, m_chunk_size} + 33'd8 > room) begin
      stop_with(ST_OVERRUN);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] fmt_value(input int at, input int len);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < len; i++) begin
      if (m_big) v = {v[23:0], m_fmt[at+i]};
      else v[8*i +: 8] = m_fmt[at+i];
    end
    return v;
  endfunction

  function automatic void parse_byte(input wavp_in_t beat, output wavp_out_t res);
    logic [7:0]  b;
    logic [31:0] off, idx;
    logic [15:0] ext;
    bit          is_audio, is_last;
    b = beat.byte_value;
    is_audio = 1'b0;
    is_last  = 1'b0;
    if (beat.file_start) clear_parser();
    if (m_phase != PH_HALT) begin
      off = m_offset;
      case (m_phase)
        PH_TAG: begin
          if (off < 4 || (off >= 8 && off < 12)) m_tag = {m_tag[23:0], b};
          else if (off < 8) gather_size_byte(b, int'(off) - 4);
          if (off == 3) begin
            if (m_tag == TAG_RIFF) m_big = 1'b0;
            else if (m_tag == TAG_RIFX) m_big = 1'b1;
            else stop_with(ST_BAD_TAG);
            m_tag = '0;
          end else if (off == 7) begin
            if (m_size_acc != m_file_size &&
                {1'b0, m_size_acc} + 33'd8 != {1'b0, m_file_size}) stop_with(ST_SIZE_BAD);
            m_size_acc = '0;
          end else if (off >= 11) begin
            if (m_tag != TAG_WAVE) stop_with(ST_NOT_WAVE);
            else open_header(PH_FMT_HDR);
          end
        end
        PH_FMT_HDR: begin
          if (take_header_byte(b, off)) begin
            if (m_tag != TAG_FMT) stop_with(ST_NOT_FMT);
            else if (m_chunk_size < FMT_MIN) stop_with(ST_FMT_BAD);
            else begin
              m_phase = PH_FMT_BODY;
              m_left  = m_chunk_size;
            end
          end
        end
        PH_FMT_BODY: begin
          idx = m_chunk_size - m_left;
          if (idx < 16) m_fmt[idx[3:0]] = b;
          else if (idx < 18) m_ext[idx[0]] = b;
          m_left--;
          if (m_left == 0) begin
            ext = m_big ? {m_ext[0], m_ext[1]} : {m_ext[1], m_ext[0]};
            if (m_chunk_size == FMT_MIN ||
                (m_chunk_size >= FMT_EXT && {16'h0, ext} == m_chunk_size - FMT_EXT))
              open_header(PH_CHUNK_HDR);
            else stop_with(ST_FMT_BAD);
          end
        end
        PH_CHUNK_HDR: begin
          if (take_header_byte(b, off)) begin
            if (m_tag == TAG_DATA) begin
              m_data_size = m_chunk_size;
              if (m_chunk_size == 0) stop_with(ST_DONE);
              else begin
                m_phase  = PH_AUDIO;
                m_left   = m_chunk_size;
                m_status = ST_AUDIO;
              end
            end else if (m_chunk_size == 0) begin
              open_header(PH_CHUNK_HDR);
            end else begin
              m_phase = PH_SKIP;
              m_left  = m_chunk_size;
            end
          end
        end
        PH_SKIP: begin
          m_left--;
          if (m_left == 0) open_header(PH_CHUNK_HDR);
        end
        PH_AUDIO: begin
          is_audio = 1'b1;
          m_left--;
          if (m_left == 0) begin
            is_last = 1'b1;
            stop_with(ST_DONE);
          end
        end
        default: stop_with(ST_EARLY);
      endcase
      if (m_offset != 32'hFFFF_FFFF) m_offset++;
      if (m_phase != PH_HALT && m_offset >= m_file_size) stop_with(ST_EARLY);
    end
    res.audio_byte      = is_audio ? b : 8'h00;
    res.audio_valid     = is_audio;
    res.audio_last      = is_last;
    res.status          = m_status;
    res.big_endian      = m_big;
    res.audio_format    = 16'(fmt_value(0, 2));
    res.num_channels    = 16'(fmt_value(2, 2));
    res.sample_rate     = fmt_value(4, 4);
    res.byte_rate       = fmt_value(8, 4);
    res.block_align     = 16'(fmt_value(12, 2));
    res.bits_per_sample = 16'(fmt_value(14, 2));
    res.data_size       = m_data_size;
  endfunction

  function automatic string describe_diff(input wavp_out_t want, input wavp_out_t got);
    string s;
    s = "";
    if (got.audio_byte !== want.audio_byte)
      s = {s, $sformatf(" audio_byte %0h/%0h", want.audio_byte, got.audio_byte)};
    if (got.audio_valid !== want.audio_valid)
      s = {s, $sformatf(" audio_valid %0b/%0b", want.audio_valid, got.audio_valid)};
    if (got.audio_last !== want.audio_last)
      s = {s, $sformatf(" audio_last %0b/%0b", want.audio_last, got.audio_last)};
    if (got.status !== want.status)
      s = {s, $sformatf(" status %0d/%0d", want.status, got.status)};
    if (got.big_endian !== want.big_endian)
      s = {s, $sformatf(" big_endian %0b/%0b", want.big_endian, got.big_endian)};
    if (got.audio_format !== want.audio_format)
      s = {s, $sformatf(" audio_format %0h/%0h", want.audio_format, got.audio_format)};
    if (got.num_channels !== want.num_channels)
      s = {s, $sformatf(" num_channels %0h/%0h", want.num_channels, got.num_channels)};
    if (got.sample_rate !== want.sample_rate)
      s = {s, $sformatf(" sample_rate %0h/%0h", want.sample_rate, got.sample_rate)};
    if (got.byte_rate !== want.byte_rate)
      s = {s, $sformatf(" byte_rate %0h/%0h", want.byte_rate, got.byte_rate)};
    if (got.block_align !== want.block_align)
      s = {s, $sformatf(" block_align %0h/%0h", want.block_align, got.block_align)};
    if (got.bits_per_sample !== want.bits_per_sample)
      s = {s, $sformatf(" bits_per_sample %0h/%0h", want.bits_per_sample, got.bits_per_sample)};
    if (got.data_size !== want.data_size)
      s = {s, $sformatf(" data_size %0h/%0h", want.data_size, got.data_size)};
    return s;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t (expected/actual):%s", $time, msg);
  endfunction

  always @(posedge clk_i) begin : result_check
    wavp_out_t want;
    string     diff;
    if (rst_ni) begin
      if (cfg_we_i) m_file_size = cfg_wdata_i;
      if (in_ch.valid && in_ch.ready) begin
        sent_beats++;
        parse_byte(in_ch.payload, want);
        predicted_beats.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_beats.size() == 0) begin
          note_mismatch(" result beat with no input beat pending");
        end else begin
          want = predicted_beats.pop_front();
          diff = describe_diff(want, out_ch.payload);
          if (diff != "") note_mismatch(diff);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always begin : sink_pacing
    int n;
    @(negedge clk_i);
    if (hold_req > 0) begin
      n = hold_req;
      hold_req = 0;
    end else begin
      n = pick_gap();
    end
    if (n > 0) begin
      out_ch.ready <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    out_ch.ready <= 1'b1;
  end

  task automatic send_beat(input logic [7:0] value, input bit first);
    wavp_in_t beat;
    int       gap;
    beat.byte_value = value;
    beat.file_start = first;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= beat;
    do @(posedge clk_i); while (!in_ch.ready);
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_file(input int count);
    for (int i = 0; i < count && i < wav_bytes.size(); i++) send_beat(wav_bytes[i], i == 0);
  endtask

  task automatic set_file_size(input logic [31:0] value);
    in_ch.valid <= 1'b0;
    while (predicted_beats.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic play_file(input logic [31:0] size_value, input int count);
    set_file_size(size_value);
    send_file(count);
  endtask

  task automatic put_tag(input logic [31:0] t);
    for (int i = 0; i < 4; i++) wav_bytes.push_back(t[8*(3-i) +: 8]);
  endtask

  task automatic put_word(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++)
      wav_bytes.push_back(gen_big ? v[8*(nbytes-1-i) +: 8] : v[8*i +: 8]);
  endtask

  task automatic put_random(input int count);
    for (int i = 0; i < count; i++) wav_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic patch_word(input int at, input logic [31:0] v);
    for (int i = 0; i < 4; i++) wav_bytes[at+i] = gen_big ? v[8*(3-i) +: 8] : v[8*i +: 8];
  endtask

  task automatic build_wav(input bit big, input int fmt_len, input int n_other,
                           input int data_len, input int tail_len);
    int n;
    wav_bytes.delete();
    gen_big = big;
    put_tag(big ? TAG_RIFX : TAG_RIFF);
    put_word(0, 4);
    put_tag(TAG_WAVE);
    put_tag(TAG_FMT);
    put_word(fmt_len, 4);
    put_random(16);
    if (fmt_len >= 18) begin
      put_word(fmt_len - 18, 2);
      put_random(fmt_len - 18);
    end else begin
      put_random(fmt_len - 16);
    end
    for (int k = 0; k < n_other; k++) begin
      for (int j = 0; j < 4; j++) wav_bytes.push_back(8'($urandom_range(ASCII_LO, ASCII_HI)));
      n = (k == 1) ? 0 : $urandom_range(0, 20);
      put_word(n, 4);
      put_random(n);
    end
    put_tag(TAG_DATA);
    put_word(data_len, 4);
    put_random(data_len);
    put_random(tail_len);
    patch_word(4, wav_bytes.size() - 8);
  endtask

  task automatic test_size_register_extremes();
    build_wav(0, 16, 0, 4, 0);
    play_file(32'd0, 6);
    build_wav(1, 16, 1, 3, 2);
    patch_word(4, 32'hFFFF_FFF7);
    play_file(32'hFFFF_FFFF, wav_bytes.size());
    build_wav(0, 16, 0, 2, 0);
    play_file(32'd4, 6);
    build_wav(1, 16, 0, 2, 0);
    patch_word(4, 32'd0);
    play_file(32'd8, 10);
  endtask

  task automatic test_header_checks();
    build_wav(0, 16, 0, 2, 0);
    wav_bytes[0] = 8'h00;
    play_file(wav_bytes.size(), 8);
    build_wav(1, 16, 0, 2, 0);
    wav_bytes[3] = 8'hFF;
    play_file(wav_bytes.size(), 8);
    build_wav(0, 16, 0, 3, 0);
    patch_word(4, wav_bytes.size());
    play_file(wav_bytes.size(), wav_bytes.size());
    build_wav(1, 16, 0, 2, 0);
    patch_word(4, wav_bytes.size() - 7);
    play_file(wav_bytes.size(), 10);
    build_wav(0, 16, 0, 2, 0);
    wav_bytes[8] = "w";
    play_file(wav_bytes.size(), 14);
  endtask

  task automatic test_chunk_checks();
    // ascii fails before fit
    build_wav(0, 16, 0, 2, 0);
    wav_bytes[13] = 8'h1F;
    patch_word(16, 32'hFFFF_0000);
    play_file(wav_bytes.size(), 24);
    build_wav(0, 16, 1, 2, 0);
    wav_bytes[37] = 8'h7F;
    play_file(wav_bytes.size(), wav_bytes.size());
    // fit fails before type
    build_wav(1, 16, 0, 2, 0);
    wav_bytes[14] = "T";
    patch_word(16, 32'd1000);
    play_file(wav_bytes.size(), 24);
    build_wav(1, 16, 0, 2, 0);
    wav_bytes[14] = "T";
    play_file(wav_bytes.size(), 24);
    build_wav(0, 16, 0, 2, 0);
    patch_word(16, 32'd12);
    play_file(wav_bytes.size(), 24);
    build_wav(0, 16, 0, 2, 0);
    patch_word(16, 32'd17);
    play_file(wav_bytes.size(), wav_bytes.size());
    build_wav(1, 20, 0, 2, 0);
    wav_bytes[37] = wav_bytes[37] ^ 8'h01;
    play_file(wav_bytes.size(), wav_bytes.size());
    build_wav(0, 16, 0, 8, 0);
    patch_word(40, 32'd9);
    play_file(wav_bytes.size(), wav_bytes.size());
    // file ends inside the fmt header
    build_wav(0, 16, 0, 2, 0);
    patch_word(4, 32'd9);
    play_file(32'd17, 20);
  endtask

  task automatic test_wellformed_files();
    for (int big = 0; big < 2; big++) begin
      build_wav(big, 16, 0, 1, 0);
      play_file(wav_bytes.size(), wav_bytes.size());
      build_wav(big, 18, 2, 6, 3);
      play_file(wav_bytes.size(), wav_bytes.size());
      build_wav(big, 22, 1, 0, 2);
      play_file(wav_bytes.size(), wav_bytes.size());
    end
  endtask

  task automatic test_restart_mid_file();
    build_wav(0, 18, 1, 30, 0);
    set_file_size(wav_bytes.size());
    send_file(25);
    send_file(wav_bytes.size() - 10);
    send_file(wav_bytes.size());
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    build_wav(1, 16, 2, 24, 0);
    set_file_size(wav_bytes.size());
    hold_req = 200;
    send_file(wav_bytes.size());
    build_wav(0, 18, 1, 12, 1);
    play_file(wav_bytes.size(), wav_bytes.size());
    calm = 1'b0;
  endtask

  task automatic test_random_files();
    int          goal, r, fmt_len, data_len, reps;
    logic [31:0] size_value;
    goal = (sent_beats + RANDOM_MIN > ITEM_TARGET) ? sent_beats + RANDOM_MIN : ITEM_TARGET;
    while (sent_beats < goal) begin
      calm = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        wav_bytes.delete();
        put_random($urandom_range(4, 30));
        set_file_size($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 40));
        for (int i = 0; i < wav_bytes.size(); i++)
          send_beat(wav_bytes[i], i == 0 || $urandom_range(0, 7) == 0);
      end else begin
        r = $urandom_range(0, 3);
        fmt_len = (r < 2) ? 16 : (r == 2) ? 18 : 18 + $urandom_range(1, 8);
        r = $urandom_range(0, 99);
        data_len = (r < 5) ? 0 : (r < 10) ? $urandom_range(150, 300) : $urandom_range(1, 40);
        build_wav($urandom_range(0, 1), fmt_len, $urandom_range(0, 3), data_len,
                  ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
        size_value = wav_bytes.size();
        r = $urandom_range(0, 99);
        if (r < 10) wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        else if (r < 15) size_value = wav_bytes.size() + $urandom_range(0, 12) - 6;
        else if (r < 18) patch_word(4, wav_bytes.size());
        else if (r < 21) size_value = $urandom_range(0, wav_bytes.size());
        set_file_size(size_value);
        reps = $urandom_range(1, 3);
        for (int k = 0; k < reps; k++)
          send_file(($urandom_range(0, 9) == 0) ? $urandom_range(1, wav_bytes.size())
                                                 : wav_bytes.size());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    calm          = 1'b0;
    hold_req      = 0;
    clear_parser();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_size_register_extremes();
    test_header_checks();
    test_chunk_checks();
    test_wellformed_files();
    test_restart_mid_file();
    test_backpressure();
    test_random_files();

    in_ch.valid <= 1'b0;
    while (predicted_beats.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    if (mismatch_count == 0 && predicted_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/wavp_pkg.sv
sv/wavp_in_if.sv
sv/wavp_out_if.sv
sv/wav_header_stream_parser.sv
test/wav_header_stream_parser_test.sv
